// File: rtl/cdsc_pkg.sv
// Shared package of the cruise distance/speed controller.
// Holds field widths, action/mode/command codes, reset values and the
// command and status structs between the controller and the datapath.
package cdsc_pkg;

  // Field widths.
  localparam int ACTION_W   = 3;
  localparam int GAP_W      = 10;
  localparam int SPEED_W    = 7;
  localparam int DIR_W      = 2;
  localparam int MODE_W     = 3;
  localparam int CMD_W      = 2;
  localparam int TIMEOUT_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Proportional speed: (gap span) * (speed span) and its serial quotient.
  localparam int PROD_W    = GAP_W + SPEED_W;
  localparam int DIV_CNT_W = $clog2(PROD_W);

  // Default speed parameters in percent.
  localparam int DEF_MIN_SPEED     = 20;
  localparam int DEF_MAX_SPEED     = 90;
  localparam int DEF_DEFAULT_SPEED = 50;
  localparam int DEF_STEP_UP       = 5;
  localparam int DEF_STEP_DOWN     = 5;
  localparam int DEF_BRAKE_STEP    = 10;

  // Reset values of the stored gaps and the configuration registers.
  localparam logic [GAP_W-1:0]     GAP_RESET           = 10'd500;
  localparam logic [GAP_W-1:0]     RST_FOLLOW_DISTANCE = 10'd100;
  localparam logic [GAP_W-1:0]     RST_EMERGENCY_GAP   = 10'd20;
  localparam logic [GAP_W-1:0]     RST_RESUME_GAP      = 10'd100;
  localparam logic [GAP_W-1:0]     RST_MIN_GAP         = 10'd30;
  localparam logic [GAP_W-1:0]     RST_SIDE_CLEAR_GAP  = 10'd50;
  localparam logic [TIMEOUT_W-1:0] RST_LANE_TIMEOUT    = 16'd20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_DISTANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMERGENCY_GAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESUME_GAP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_CLEAR_GAP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LANE_TIMEOUT    = 3'd5;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_UPDATE  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ENABLE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DISABLE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_TARGET  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_LANE    = 3'd4;

  // Mode codes.
  localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CRUISE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FOLLOW = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EMERG  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd5;

  // Lane directions and turn commands.
  localparam logic [DIR_W-1:0] DIR_NONE  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;

  localparam logic [CMD_W-1:0] TURN_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] TURN_LEFT  = 2'd1;
  localparam logic [CMD_W-1:0] TURN_RIGHT = 2'd2;

  // Motor commands.
  localparam logic [CMD_W-1:0] MOTOR_NONE    = 2'd0;
  localparam logic [CMD_W-1:0] MOTOR_FORWARD = 2'd1;
  localparam logic [CMD_W-1:0] MOTOR_STOP    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic div_load;
    logic div_step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/cdsc_item_if.sv
// Input channel of the cruise controller: valid/ready plus one action item.
// Depends on cdsc_pkg for the field widths.
interface cdsc_item_if;
  logic                             valid;
  logic                             ready;
  logic [cdsc_pkg::ACTION_W-1:0]    action;
  logic [cdsc_pkg::GAP_W-1:0]       front_gap;
  logic [cdsc_pkg::GAP_W-1:0]       left_gap;
  logic [cdsc_pkg::GAP_W-1:0]       right_gap;
  logic [cdsc_pkg::SPEED_W-1:0]     speed_request;
  logic [cdsc_pkg::DIR_W-1:0]       lane_direction;

  modport source (
    output valid, action, front_gap, left_gap, right_gap, speed_request, lane_direction,
    input  ready
  );
  modport sink (
    input  valid, action, front_gap, left_gap, right_gap, speed_request, lane_direction,
    output ready
  );
endinterface

// File: rtl/cdsc_result_if.sv
// Result channel of the cruise controller: valid/ready plus one status item.
// Depends on cdsc_pkg for the field widths.
interface cdsc_result_if;
  logic                          valid;
  logic                          ready;
  logic [cdsc_pkg::MODE_W-1:0]   mode;
  logic [cdsc_pkg::SPEED_W-1:0]  speed_now;
  logic                          braking;
  logic                          obstacle;
  logic [cdsc_pkg::CMD_W-1:0]    turn_command;
  logic [cdsc_pkg::CMD_W-1:0]    motor_command;

  modport source (
    output valid, mode, speed_now, braking, obstacle, turn_command, motor_command,
    input  ready
  );
  modport sink (
    input  valid, mode, speed_now, braking, obstacle, turn_command, motor_command,
    output ready
  );
endinterface

// File: rtl/cdsc_ctrl.sv
// Sequencing state machine of the cruise controller.
// Depends on cdsc_pkg for the command and status structs.
module cdsc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cdsc_pkg::sts_t  sts,
  output cdsc_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MUL    = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_MUL;
        end
      end
      ST_MUL: begin
        // The product is registered into the divider here.
        cmd.div_load = 1'b1;
        state_next   = sts.need_div ? ST_DIV : ST_COMMIT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/cdsc_datapath.sv
// Datapath of the cruise controller: configuration and mode state, the
// proportional speed multiplier, a serial restoring divider and the result
// register. Depends on cdsc_pkg.
module cdsc_datapath #(
  parameter int MIN_SPEED     = cdsc_pkg::DEF_MIN_SPEED,
  parameter int MAX_SPEED     = cdsc_pkg::DEF_MAX_SPEED,
  parameter int DEFAULT_SPEED = cdsc_pkg::DEF_DEFAULT_SPEED,
  parameter int STEP_UP       = cdsc_pkg::DEF_STEP_UP,
  parameter int STEP_DOWN     = cdsc_pkg::DEF_STEP_DOWN,
  parameter int BRAKE_STEP    = cdsc_pkg::DEF_BRAKE_STEP
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration writes.
  input  logic                               cfg_we,
  input  logic [cdsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cdsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Input payload.
  input  logic [cdsc_pkg::ACTION_W-1:0]      action,
  input  logic [cdsc_pkg::GAP_W-1:0]         front_gap,
  input  logic [cdsc_pkg::GAP_W-1:0]         left_gap,
  input  logic [cdsc_pkg::GAP_W-1:0]         right_gap,
  input  logic [cdsc_pkg::SPEED_W-1:0]       speed_request,
  input  logic [cdsc_pkg::DIR_W-1:0]         lane_direction,
  // Result register.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cdsc_pkg::MODE_W-1:0]        out_mode,
  output logic [cdsc_pkg::SPEED_W-1:0]       out_speed,
  output logic                               out_braking,
  output logic                               out_obstacle,
  output logic [cdsc_pkg::CMD_W-1:0]         out_turn,
  output logic [cdsc_pkg::CMD_W-1:0]         out_motor,
  // Controller link.
  input  cdsc_pkg::cmd_t                     cmd,
  output cdsc_pkg::sts_t                     sts
);

  localparam int GW = cdsc_pkg::GAP_W;
  localparam int SW = cdsc_pkg::SPEED_W;
  localparam int TW = cdsc_pkg::TIMEOUT_W;
  localparam int PW = cdsc_pkg::PROD_W;
  localparam int CW = cdsc_pkg::DIV_CNT_W;

  // Speed arithmetic runs one bit wider than the stored speed.
  localparam logic [SW:0] MinSp   = (SW+1)'(MIN_SPEED);
  localparam logic [SW:0] MaxSp   = (SW+1)'(MAX_SPEED);
  localparam logic [SW:0] DefSp   = (SW+1)'(DEFAULT_SPEED);
  localparam logic [SW:0] StepUp  = (SW+1)'(STEP_UP);
  localparam logic [SW:0] StepDn  = (SW+1)'(STEP_DOWN);
  localparam logic [SW:0] BrakeSt = (SW+1)'(BRAKE_STEP);
  localparam logic [CW-1:0] DivLast = CW'(PW - 1);
  localparam logic [TW-1:0] ElapsedMax = {TW{1'b1}};

  // Configuration registers.
  logic [GW-1:0] follow_distance, emergency_gap, resume_gap, min_gap, side_clear_gap;
  logic [TW-1:0] lane_timeout;

  // Architectural state.
  logic [cdsc_pkg::MODE_W-1:0] mode, mode_next;
  logic [SW-1:0]               speed, speed_next;
  logic [SW-1:0]               target, target_next;
  logic [GW-1:0]               gap_front, gap_front_next;
  logic [GW-1:0]               gap_left, gap_left_next;
  logic [GW-1:0]               gap_right, gap_right_next;
  logic [cdsc_pkg::DIR_W-1:0]  lane_request, lane_request_next;
  logic                        lane_active, lane_active_next;
  logic [TW-1:0]               lane_elapsed, lane_elapsed_next;
  logic                        brake_flag, brake_flag_next;
  logic [cdsc_pkg::CMD_W-1:0]  turn_next, motor_next;
  logic                        obstacle_next;

  // Latched transaction.
  logic [cdsc_pkg::ACTION_W-1:0] item_action;
  logic [GW-1:0]                 item_front, item_left, item_right;
  logic [SW-1:0]                 item_speed;
  logic [cdsc_pkg::DIR_W-1:0]    item_dir;

  // Divider.
  logic [GW-1:0] div_rem;
  logic [PW-1:0] div_quo;
  logic [CW-1:0] div_cnt;

  // Shared terms.
  logic [GW-1:0] fol, den, mul_a;
  logic [SW-1:0] diff;
  logic [PW-1:0] product;
  logic [GW:0]   trial;
  logic          trial_ge;
  logic [SW:0]   req_clamped;

  // Effective following gap and the proportional span.
  assign fol   = (follow_distance > min_gap) ? follow_distance : min_gap;
  assign den   = fol - min_gap;
  assign diff  = ({1'b0, target} > MinSp) ? SW'({1'b0, target} - MinSp) : '0;
  assign mul_a = item_front - min_gap;
  assign product = {{SW{1'b0}}, mul_a} * {{GW{1'b0}}, diff};

  // One restoring division step.
  assign trial    = {div_rem, div_quo[PW-1]};
  assign trial_ge = trial >= {1'b0, den};

  // Speed request clamped up to the minimum, then down to the maximum.
  always_comb begin
    req_clamped = ({1'b0, item_speed} < MinSp) ? MinSp : {1'b0, item_speed};
    if (req_clamped > MaxSp) begin
      req_clamped = MaxSp;
    end
  end

  // Status to the controller.
  assign sts.need_div = (item_action == cdsc_pkg::ACT_UPDATE) &&
                        ((mode == cdsc_pkg::MODE_CRUISE) || (mode == cdsc_pkg::MODE_FOLLOW));
  assign sts.div_last = (div_cnt == DivLast);
  assign sts.out_free = !out_valid || out_ready;

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      follow_distance <= cdsc_pkg::RST_FOLLOW_DISTANCE;
      emergency_gap   <= cdsc_pkg::RST_EMERGENCY_GAP;
      resume_gap      <= cdsc_pkg::RST_RESUME_GAP;
      min_gap         <= cdsc_pkg::RST_MIN_GAP;
      side_clear_gap  <= cdsc_pkg::RST_SIDE_CLEAR_GAP;
      lane_timeout    <= cdsc_pkg::RST_LANE_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        cdsc_pkg::CFG_FOLLOW_DISTANCE: follow_distance <= cfg_data[GW-1:0];
        cdsc_pkg::CFG_EMERGENCY_GAP:   emergency_gap   <= cfg_data[GW-1:0];
        cdsc_pkg::CFG_RESUME_GAP:      resume_gap      <= cfg_data[GW-1:0];
        cdsc_pkg::CFG_MIN_GAP:         min_gap         <= cfg_data[GW-1:0];
        cdsc_pkg::CFG_SIDE_CLEAR_GAP:  side_clear_gap  <= cfg_data[GW-1:0];
        cdsc_pkg::CFG_LANE_TIMEOUT:    lane_timeout    <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // Transaction capture.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_action <= action;
      item_front  <= front_gap;
      item_left   <= left_gap;
      item_right  <= right_gap;
      item_speed  <= speed_request;
      item_dir    <= lane_direction;
    end
  end

  // Serial divider: the product is loaded, then one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_rem <= '0;
      div_quo <= product;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= trial_ge ? GW'(trial - {1'b0, den}) : trial[GW-1:0];
      div_quo <= {div_quo[PW-2:0], trial_ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // Next architectural state for the latched transaction.
  always_comb begin
    logic [SW:0] sp;
    logic [SW:0] want;
    logic [SW:0] delta;
    logic        run_lane;
    logic        safe;

    mode_next         = mode;
    speed_next        = speed;
    target_next       = target;
    gap_front_next    = gap_front;
    gap_left_next     = gap_left;
    gap_right_next    = gap_right;
    lane_request_next = lane_request;
    lane_active_next  = lane_active;
    lane_elapsed_next = lane_elapsed;
    brake_flag_next   = brake_flag;
    turn_next         = cdsc_pkg::TURN_NONE;
    motor_next        = cdsc_pkg::MOTOR_NONE;
    sp                = {1'b0, speed};
    want              = {1'b0, target};
    delta             = '0;
    run_lane          = 1'b0;
    safe              = 1'b0;

    case (item_action)
      cdsc_pkg::ACT_UPDATE: begin
        gap_front_next = item_front;
        gap_left_next  = item_left;
        gap_right_next = item_right;
        if (lane_active && (lane_elapsed != ElapsedMax)) begin
          lane_elapsed_next = lane_elapsed + 1'b1;
        end

        if ((mode == cdsc_pkg::MODE_CRUISE) || (mode == cdsc_pkg::MODE_FOLLOW)) begin
          // Speed control.
          if (item_front <= emergency_gap) begin
            mode_next = cdsc_pkg::MODE_EMERG;
          end else begin
            if (item_front < fol) begin
              mode_next = cdsc_pkg::MODE_FOLLOW;
              if (item_front < min_gap) begin
                want = MinSp;
              end else begin
                want = MinSp + {1'b0, div_quo[SW-1:0]};
              end
            end else begin
              mode_next = cdsc_pkg::MODE_CRUISE;
            end
            if (want > sp) begin
              delta = want - sp;
              sp    = sp + ((delta > StepUp) ? StepUp : delta);
            end else if (want < sp) begin
              delta = sp - want;
              sp    = sp - ((delta > StepDn) ? StepDn : delta);
            end
          end

          // Obstacle handling with the fresh side gaps.
          if ((item_front <= min_gap) && (sp[SW-1:0] != '0)) begin
            if (item_left >= side_clear_gap) begin
              lane_request_next = cdsc_pkg::DIR_LEFT;
              mode_next         = cdsc_pkg::MODE_LEFT;
            end else if (item_right >= side_clear_gap) begin
              lane_request_next = cdsc_pkg::DIR_RIGHT;
              mode_next         = cdsc_pkg::MODE_RIGHT;
            end else begin
              mode_next = cdsc_pkg::MODE_EMERG;
            end
          end
          run_lane = 1'b1;
        end else if (mode == cdsc_pkg::MODE_EMERG) begin
          // Emergency deceleration and resume.
          if (sp != '0) begin
            sp              = (sp >= BrakeSt) ? (sp - BrakeSt) : '0;
            brake_flag_next = 1'b1;
          end else begin
            motor_next = cdsc_pkg::MOTOR_STOP;
          end
          if (item_front > resume_gap) begin
            mode_next       = cdsc_pkg::MODE_CRUISE;
            brake_flag_next = 1'b0;
            motor_next      = cdsc_pkg::MOTOR_FORWARD;
          end
        end else if ((mode == cdsc_pkg::MODE_LEFT) || (mode == cdsc_pkg::MODE_RIGHT)) begin
          run_lane = 1'b1;
        end

        // Lane change start and timeout.
        if (run_lane) begin
          if ((lane_request_next != cdsc_pkg::DIR_NONE) && !lane_active_next) begin
            if (lane_request_next == cdsc_pkg::DIR_LEFT) begin
              safe = item_left >= side_clear_gap;
            end else if (lane_request_next == cdsc_pkg::DIR_RIGHT) begin
              safe = item_right >= side_clear_gap;
            end
            if (safe) begin
              lane_active_next  = 1'b1;
              lane_elapsed_next = '0;
              turn_next = (lane_request_next == cdsc_pkg::DIR_LEFT) ?
                          cdsc_pkg::TURN_LEFT : cdsc_pkg::TURN_RIGHT;
            end else begin
              lane_request_next = cdsc_pkg::DIR_NONE;
              lane_active_next  = 1'b0;
              lane_elapsed_next = '0;
            end
          end
          if (lane_active_next && (lane_elapsed_next > lane_timeout)) begin
            lane_request_next = cdsc_pkg::DIR_NONE;
            lane_active_next  = 1'b0;
            lane_elapsed_next = '0;
            mode_next         = cdsc_pkg::MODE_CRUISE;
            motor_next        = cdsc_pkg::MOTOR_FORWARD;
          end
        end
      end
      cdsc_pkg::ACT_ENABLE: begin
        target_next     = req_clamped[SW-1:0];
        sp              = MinSp;
        mode_next       = cdsc_pkg::MODE_CRUISE;
        brake_flag_next = 1'b0;
        motor_next      = cdsc_pkg::MOTOR_FORWARD;
      end
      cdsc_pkg::ACT_DISABLE: begin
        mode_next         = cdsc_pkg::MODE_OFF;
        sp                = '0;
        brake_flag_next   = 1'b0;
        lane_request_next = cdsc_pkg::DIR_NONE;
        motor_next        = cdsc_pkg::MOTOR_STOP;
      end
      cdsc_pkg::ACT_TARGET: begin
        target_next = req_clamped[SW-1:0];
      end
      cdsc_pkg::ACT_LANE: begin
        if (((mode == cdsc_pkg::MODE_CRUISE) || (mode == cdsc_pkg::MODE_FOLLOW)) &&
            ((item_dir == cdsc_pkg::DIR_LEFT) || (item_dir == cdsc_pkg::DIR_RIGHT))) begin
          lane_request_next = item_dir;
        end
      end
      default: ;
    endcase

    speed_next    = sp[SW-1:0];
    obstacle_next = gap_front_next < fol;
  end

  // Architectural state update on commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= cdsc_pkg::MODE_OFF;
      speed        <= '0;
      target       <= DefSp[SW-1:0];
      gap_front    <= cdsc_pkg::GAP_RESET;
      gap_left     <= cdsc_pkg::GAP_RESET;
      gap_right    <= cdsc_pkg::GAP_RESET;
      lane_request <= cdsc_pkg::DIR_NONE;
      lane_active  <= 1'b0;
      lane_elapsed <= '0;
      brake_flag   <= 1'b0;
    end else if (cmd.commit) begin
      mode         <= mode_next;
      speed        <= speed_next;
      target       <= target_next;
      gap_front    <= gap_front_next;
      gap_left     <= gap_left_next;
      gap_right    <= gap_right_next;
      lane_request <= lane_request_next;
      lane_active  <= lane_active_next;
      lane_elapsed <= lane_elapsed_next;
      brake_flag   <= brake_flag_next;
    end
  end

  // Result register: holds a transaction until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_mode     <= mode_next;
      out_speed    <= speed_next;
      out_braking  <= brake_flag_next;
      out_obstacle <= obstacle_next;
      out_turn     <= turn_next;
      out_motor    <= motor_next;
    end
  end

endmodule

// File: rtl/cruise_distance_speed_controller_unit.sv
// Adaptive cruise mode machine: controller and datapath joined by command/status.
// Per accepted transaction an update in cruise or following mode passes the multiply
// state, 17 serial divider steps and the commit state; other items skip the divider.
// One transaction at a time; a new one is taken the cycle after the result is
// registered, while that result may still wait for the sink.
// Synchronous active-high reset restores FSM, config, arch state and out_valid.
module cruise_distance_speed_controller_unit #(
  parameter int MIN_SPEED     = cdsc_pkg::DEF_MIN_SPEED,
  parameter int MAX_SPEED     = cdsc_pkg::DEF_MAX_SPEED,
  parameter int DEFAULT_SPEED = cdsc_pkg::DEF_DEFAULT_SPEED,
  parameter int STEP_UP       = cdsc_pkg::DEF_STEP_UP,
  parameter int STEP_DOWN     = cdsc_pkg::DEF_STEP_DOWN,
  parameter int BRAKE_STEP    = cdsc_pkg::DEF_BRAKE_STEP
) (
  input  logic                            clk,
  input  logic                            rst,
  cdsc_item_if.sink                       item,
  cdsc_result_if.source                   result,
  input  logic                            cfg_we,
  input  logic [cdsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdsc_pkg::CFG_DATA_W-1:0] cfg_data
);

  cdsc_pkg::cmd_t cmd;
  cdsc_pkg::sts_t sts;
  logic           in_ready;

  assign item.ready = in_ready;

  // Sequencer.
  cdsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // State, arithmetic and result register.
  cdsc_datapath #(
    .MIN_SPEED     (MIN_SPEED),
    .MAX_SPEED     (MAX_SPEED),
    .DEFAULT_SPEED (DEFAULT_SPEED),
    .STEP_UP       (STEP_UP),
    .STEP_DOWN     (STEP_DOWN),
    .BRAKE_STEP    (BRAKE_STEP)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .action         (item.action),
    .front_gap      (item.front_gap),
    .left_gap       (item.left_gap),
    .right_gap      (item.right_gap),
    .speed_request  (item.speed_request),
    .lane_direction (item.lane_direction),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_mode       (result.mode),
    .out_speed      (result.speed_now),
    .out_braking    (result.braking),
    .out_obstacle   (result.obstacle),
    .out_turn       (result.turn_command),
    .out_motor      (result.motor_command),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
